// ===== rtl/core/hvd_pkg.sv =====
// Shared types, widths and constants of the haversine distance pipeline.
package hvd_pkg;

    localparam int STAGES     = 30;
    localparam int SQRT_STEPS = 31;
    localparam int XY_W       = 33;
    localparam int Z_W        = 34;
    localparam int Q_W        = 32;
    localparam int SQ_W       = 62;
    localparam int WRAP_W     = 36;
    localparam int LANES      = 4;

    localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [Q_W-1:0]  ONE_Q30     = 32'sd1073741824;
    localparam logic [30:0]            DEG2RAD_Q36 = 31'd1199381129;
    localparam logic [23:0]            TWO_RADIUS  = 24'd12742000;
    localparam logic [24:0]            MAX_DIST    = 25'd20015087;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sqrt_t;

    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:  val = 34'sd843314857;
            1:  val = 34'sd497837829;
            2:  val = 34'sd263043837;
            3:  val = 34'sd133525159;
            4:  val = 34'sd67021687;
            5:  val = 34'sd33543516;
            6:  val = 34'sd16775851;
            7:  val = 34'sd8388437;
            8:  val = 34'sd4194283;
            9:  val = 34'sd2097149;
            10: val = 34'sd1048576;
            11: val = 34'sd524288;
            12: val = 34'sd262144;
            13: val = 34'sd131072;
            14: val = 34'sd65536;
            15: val = 34'sd32768;
            16: val = 34'sd16384;
            17: val = 34'sd8192;
            18: val = 34'sd4096;
            19: val = 34'sd2048;
            20: val = 34'sd1024;
            21: val = 34'sd512;
            22: val = 34'sd256;
            23: val = 34'sd128;
            24: val = 34'sd64;
            25: val = 34'sd32;
            26: val = 34'sd16;
            27: val = 34'sd8;
            28: val = 34'sd4;
            29: val = 34'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/haversine_distance_top.sv =====
// Throughput: one request per cycle while request_stall is low; every stage is a register, and
// the rows are two 30-cell CORDIC rows, a 31-cell root row and the angle reduction.
// The whole row advances together; it halts only while a result waits under stall.
// Reset (rst_n, async, active low) clears the valid line only; payload is not reset.
module haversine_distance_top
    import hvd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 22
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    output logic               request_stall,
    input  logic signed [29:0] first_latitude,
    input  logic signed [30:0] first_longitude,
    input  logic signed [29:0] second_latitude,
    input  logic signed [30:0] second_longitude,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [24:0]        distance_metres
);

    // Angle reduction: bias every angle up by half a turn plus a large multiple of a
    // full turn so it is positive, strip full turns with a row of compare/subtract
    // cells from the largest multiple down, then remove the half turn again.
    localparam logic [WRAP_W-1:0] FULL       = WRAP_W'(64'd360 << ANGLE_FRAC_BITS);
    localparam logic [WRAP_W-1:0] HALF       = FULL >> 1;
    localparam int                FULL_LOG   = $clog2(FULL);
    localparam int                WRAP_TOP   = 34 - FULL_LOG;
    localparam int                WRAP_STEPS = WRAP_TOP + 1;
    localparam logic [WRAP_W-1:0] BIAS       = HALF + (FULL << WRAP_TOP);

    // Degrees to Q30 radians: full angle for the latitudes, half angle for the deltas.
    localparam int          SH_FULL    = 6 + ANGLE_FRAC_BITS;
    localparam int          SH_HALF    = 7 + ANGLE_FRAC_BITS;
    localparam logic [63:0] ROUND_FULL = 64'd1 << (SH_FULL - 1);
    localparam logic [63:0] ROUND_HALF = 64'd1 << (SH_HALF - 1);

    // input, wrap row, mag/mult/round/fold, rotation row, clamp, three product stages,
    // root row, vectoring row, scale, output
    localparam int LAT = 1 + WRAP_STEPS + 4 + STAGES + 1 + 3 + SQRT_STEPS + STAGES + 2;

    // Lane order through the front end: half delta latitude, half delta longitude,
    // first latitude, second latitude.
    localparam int LN_DLAT = 0;
    localparam int LN_DLON = 1;
    localparam int LN_LAT1 = 2;
    localparam int LN_LAT2 = 3;

    function automatic logic signed [Q_W-1:0] mul_q30(input logic signed [Q_W-1:0] a,
                                                      input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] p;
        p = a * b;
        p = p + (2*Q_W)'(64'sd536870912);
        return Q_W'(p >>> 30);
    endfunction

    function automatic logic signed [Q_W-1:0] clamp_q30(input logic signed [XY_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > XY_W'(ONE_Q30))
        begin
            r = ONE_Q30;
        end
        else if (v < -XY_W'(ONE_Q30))
        begin
            r = -ONE_Q30;
        end
        else
        begin
            r = Q_W'(v);
        end
        return r;
    endfunction

    // Row control: one shared advance, a valid bit per stage.
    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign adv           = !(vld_reg[LAT-1] && result_stall);
    assign request_stall = !adv;
    assign result_valid  = vld_reg[LAT-1];

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], request_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    // Entry stage: form the four angles and bias them positive.
    logic signed [WRAP_W-1:0] lat1_x;
    logic signed [WRAP_W-1:0] lat2_x;
    logic signed [WRAP_W-1:0] lon1_x;
    logic signed [WRAP_W-1:0] lon2_x;
    logic [WRAP_W-1:0]        bias_next [0:LANES-1];
    logic [WRAP_W-1:0]        bias_reg  [0:LANES-1];

    always_comb
    begin
        lat1_x = {{(WRAP_W-30){first_latitude[29]}}, first_latitude};
        lat2_x = {{(WRAP_W-30){second_latitude[29]}}, second_latitude};
        lon1_x = {{(WRAP_W-31){first_longitude[30]}}, first_longitude};
        lon2_x = {{(WRAP_W-31){second_longitude[30]}}, second_longitude};
        bias_next[LN_DLAT] = WRAP_W'((lat2_x - lat1_x) + $signed(BIAS));
        bias_next[LN_DLON] = WRAP_W'((lon2_x - lon1_x) + $signed(BIAS));
        bias_next[LN_LAT1] = WRAP_W'(lat1_x + $signed(BIAS));
        bias_next[LN_LAT2] = WRAP_W'(lat2_x + $signed(BIAS));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bias_reg <= bias_next;
        end
    end

    // Wrap row.
    logic [WRAP_W-1:0] wrap_v [0:WRAP_STEPS][0:LANES-1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_wrap_in
        assign wrap_v[0][l] = bias_reg[l];
    end

    for (genvar g = 0; g < WRAP_STEPS; g++)
    begin : g_wrap
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            hvd_wrap_cell #(
                .SUB (FULL << (WRAP_TOP - g))
            ) u_cell (
                .clk  (clk),
                .en   (adv),
                .din  (wrap_v[g][l]),
                .dout (wrap_v[g+1][l])
            );
        end
    end

    // Remove the half-turn bias, take magnitude and sign.
    logic signed [WRAP_W-1:0] rem_s     [0:LANES-1];
    logic [32:0]              mag_next  [0:LANES-1];
    logic [32:0]              mag_reg   [0:LANES-1];
    logic [LANES-1:0]         neg_b_reg;
    logic [LANES-1:0]         neg_b_next;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_s[l]      = $signed(wrap_v[WRAP_STEPS][l]) - $signed(HALF);
            neg_b_next[l] = rem_s[l][WRAP_W-1];
            mag_next[l]   = neg_b_next[l] ? 33'(-rem_s[l]) : 33'(rem_s[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg   <= mag_next;
            neg_b_reg <= neg_b_next;
        end
    end

    // Scale by pi/180.
    logic [63:0]      prod_reg  [0:LANES-1];
    logic [63:0]      prod_next [0:LANES-1];
    logic [LANES-1:0] neg_c_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            prod_next[l] = 64'(mag_reg[l]) * 64'(DEG2RAD_Q36);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= prod_next;
            neg_c_reg <= neg_b_reg;
        end
    end

    // Round half up on the magnitude, then restore the sign.
    logic [63:0]           qmag       [0:LANES-1];
    logic signed [Z_W-1:0] theta_next [0:LANES-1];
    logic signed [Z_W-1:0] theta_reg  [0:LANES-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (l == LN_DLAT || l == LN_DLON)
            begin
                qmag[l] = (prod_reg[l] + ROUND_HALF) >> SH_HALF;
            end
            else
            begin
                qmag[l] = (prod_reg[l] + ROUND_FULL) >> SH_FULL;
            end
            theta_next[l] = neg_c_reg[l] ? -$signed(Z_W'(qmag[l])) : $signed(Z_W'(qmag[l]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            theta_reg <= theta_next;
        end
    end

    // Fold latitudes beyond a quarter turn by pi; remember to negate their cosine.
    cordic_t               rot_in_next [0:LANES-1];
    cordic_t               rot_in_reg  [0:LANES-1];
    logic [1:0]            fold_next;
    logic [1:0]            fold_reg;
    logic signed [Z_W-1:0] folded      [0:LANES-1];

    always_comb
    begin
        fold_next = '0;
        for (int l = 0; l < LANES; l++)
        begin
            folded[l] = theta_reg[l];
            if (l == LN_LAT1 || l == LN_LAT2)
            begin
                if (theta_reg[l] > HALF_PI_Q30)
                begin
                    folded[l]              = theta_reg[l] - PI_Q30;
                    fold_next[l - LN_LAT1] = 1'b1;
                end
                else if (theta_reg[l] < -HALF_PI_Q30)
                begin
                    folded[l]              = theta_reg[l] + PI_Q30;
                    fold_next[l - LN_LAT1] = 1'b1;
                end
            end
            rot_in_next[l].x = CORDIC_GAIN;
            rot_in_next[l].y = '0;
            rot_in_next[l].z = folded[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_in_reg <= rot_in_next;
            fold_reg   <= fold_next;
        end
    end

    // Rotation row: sine of the half deltas, cosine of the latitudes.
    cordic_t    rot_v     [0:STAGES][0:LANES-1];
    logic [1:0] fold_line [0:STAGES];

    assign fold_line[0] = fold_reg;

    for (genvar l = 0; l < LANES; l++)
    begin : g_rot_in
        assign rot_v[0][l] = rot_in_reg[l];
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_rot
        logic [1:0] fold_s_reg;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                fold_s_reg <= fold_line[s];
            end
        end

        assign fold_line[s+1] = fold_s_reg;

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            hvd_cordic_cell #(
                .SHIFT  (s),
                .VECTOR (1'b0)
            ) u_cell (
                .clk  (clk),
                .en   (adv),
                .din  (rot_v[s][l]),
                .dout (rot_v[s+1][l])
            );
        end
    end

    // Clamp the trig results to [-1, 1] and apply the fold sign.
    logic signed [Q_W-1:0] s1_reg;
    logic signed [Q_W-1:0] s2_reg;
    logic signed [Q_W-1:0] c1_reg;
    logic signed [Q_W-1:0] c2_reg;
    logic signed [Q_W-1:0] s1_next;
    logic signed [Q_W-1:0] s2_next;
    logic signed [Q_W-1:0] c1_next;
    logic signed [Q_W-1:0] c2_next;

    always_comb
    begin
        s1_next = clamp_q30(rot_v[STAGES][LN_DLAT].y);
        s2_next = clamp_q30(rot_v[STAGES][LN_DLON].y);
        c1_next = clamp_q30(rot_v[STAGES][LN_LAT1].x);
        c2_next = clamp_q30(rot_v[STAGES][LN_LAT2].x);
        if (fold_line[STAGES][0])
        begin
            c1_next = -c1_next;
        end
        if (fold_line[STAGES][1])
        begin
            c2_next = -c2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            c1_reg <= c1_next;
            c2_reg <= c2_next;
        end
    end

    // a = s1^2 + (c1 c2) s2^2, one multiplier level per stage.
    logic signed [Q_W-1:0] ss1_reg;
    logic signed [Q_W-1:0] ss2_reg;
    logic signed [Q_W-1:0] cc_reg;
    logic signed [Q_W-1:0] ss1_p2_reg;
    logic signed [Q_W-1:0] term_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss1_reg    <= mul_q30(s1_reg, s1_reg);
            ss2_reg    <= mul_q30(s2_reg, s2_reg);
            cc_reg     <= mul_q30(c1_reg, c2_reg);
            ss1_p2_reg <= ss1_reg;
            term_reg   <= mul_q30(cc_reg, ss2_reg);
        end
    end

    // Clamp a to [0, 1] and load both root lanes with a and 1 - a, scaled by 2^30.
    logic signed [Q_W:0] a_sum;
    logic [30:0]         a_clamped;
    logic [30:0]         b_val;
    sqrt_t               sq_in_next [0:1];
    sqrt_t               sq_in_reg  [0:1];

    always_comb
    begin
        a_sum = (Q_W+1)'(ss1_p2_reg) + (Q_W+1)'(term_reg);
        if (a_sum[Q_W])
        begin
            a_clamped = '0;
        end
        else if (a_sum > (Q_W+1)'(ONE_Q30))
        begin
            a_clamped = 31'(ONE_Q30);
        end
        else
        begin
            a_clamped = 31'(a_sum);
        end
        b_val              = 31'(ONE_Q30) - a_clamped;
        sq_in_next[0].rem  = SQ_W'(a_clamped) << 30;
        sq_in_next[0].root = '0;
        sq_in_next[1].rem  = SQ_W'(b_val) << 30;
        sq_in_next[1].root = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_in_reg <= sq_in_next;
        end
    end

    // Root row: sqrt(a) and sqrt(1 - a) side by side.
    sqrt_t sq_v [0:SQRT_STEPS][0:1];

    for (genvar l = 0; l < 2; l++)
    begin : g_sq_in
        assign sq_v[0][l] = sq_in_reg[l];
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            hvd_sqrt_cell #(
                .STEP (k)
            ) u_cell (
                .clk  (clk),
                .en   (adv),
                .din  (sq_v[k][l]),
                .dout (sq_v[k+1][l])
            );
        end
    end

    // Vectoring row: angle of (sqrt(1 - a), sqrt(a)).
    cordic_t vec_v [0:STAGES];

    assign vec_v[0].x = XY_W'(sq_v[SQRT_STEPS][1].root);
    assign vec_v[0].y = XY_W'(sq_v[SQRT_STEPS][0].root);
    assign vec_v[0].z = '0;

    for (genvar s = 0; s < STAGES; s++)
    begin : g_vec
        hvd_cordic_cell #(
            .SHIFT  (s),
            .VECTOR (1'b1)
        ) u_cell (
            .clk  (clk),
            .en   (adv),
            .din  (vec_v[s]),
            .dout (vec_v[s+1])
        );
    end

    // Scale the central half angle by the diameter, then round and saturate.
    logic signed [Z_W-1:0] z_fin;
    logic [30:0]           z_pos;
    logic [54:0]           dist_prod_reg;
    logic [54:0]           dist_prod_next;
    logic [24:0]           dist_rnd;
    logic [24:0]           distance_reg;
    logic [24:0]           distance_next;

    always_comb
    begin
        z_fin          = vec_v[STAGES].z;
        z_pos          = z_fin[Z_W-1] ? '0 : 31'(z_fin);
        dist_prod_next = 55'(z_pos) * 55'(TWO_RADIUS);
    end

    always_comb
    begin
        dist_rnd      = 25'((dist_prod_reg + 55'd536870912) >> 30);
        distance_next = (dist_rnd > MAX_DIST) ? MAX_DIST : dist_rnd;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_prod_reg <= dist_prod_next;
            distance_reg  <= distance_next;
        end
    end

    assign distance_metres = distance_reg;

endmodule

// ===== rtl/core/hvd_wrap_cell.sv =====
// One conditional-subtract step of the modulo-360-degree angle reduction.
module hvd_wrap_cell
    import hvd_pkg::*;
#(
    parameter logic [WRAP_W-1:0] SUB = '0
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [WRAP_W-1:0] din,
    output logic [WRAP_W-1:0] dout
);

    logic [WRAP_W-1:0] val_reg;
    logic [WRAP_W-1:0] val_next;

    always_comb
    begin
        val_next = (din >= SUB) ? din - SUB : din;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
        end
    end

    assign dout = val_reg;

endmodule

// ===== rtl/core/hvd_cordic_cell.sv =====
// One CORDIC micro-rotation, rotation or vectoring mode, with its output register.
module hvd_cordic_cell
    import hvd_pkg::*;
#(
    parameter int SHIFT  = 0,
    parameter bit VECTOR = 1'b0
)
(
    input  logic    clk,
    input  logic    en,
    input  cordic_t din,
    output cordic_t dout
);

    localparam logic signed [Z_W-1:0] ANGLE = atan_q30(SHIFT);

    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  zs;
    logic                   go_pos;
    cordic_t                step_reg;
    cordic_t                step_next;

    always_comb
    begin
        xs = din.x;
        ys = din.y;
        zs = din.z;
        // vectoring drives y toward zero, rotation drives z toward zero
        go_pos = VECTOR ? ys[XY_W-1] : !zs[Z_W-1];
        if (go_pos)
        begin
            step_next.x = xs - (ys >>> SHIFT);
            step_next.y = ys + (xs >>> SHIFT);
            step_next.z = zs - ANGLE;
        end
        else
        begin
            step_next.x = xs + (ys >>> SHIFT);
            step_next.y = ys - (xs >>> SHIFT);
            step_next.z = zs + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg <= step_next;
        end
    end

    assign dout = step_reg;

endmodule

// ===== rtl/core/hvd_sqrt_cell.sv =====
// One digit step of the bit-serial integer square root.
module hvd_sqrt_cell
    import hvd_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic  clk,
    input  logic  en,
    input  sqrt_t din,
    output sqrt_t dout
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

    logic [SQ_W-1:0] trial;
    sqrt_t           step_reg;
    sqrt_t           step_next;

    always_comb
    begin
        trial = din.root + BIT;
        if (din.rem >= trial)
        begin
            step_next.rem  = din.rem - trial;
            step_next.root = (din.root >> 1) + BIT;
        end
        else
        begin
            step_next.rem  = din.rem;
            step_next.root = din.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            step_reg <= step_next;
        end
    end

    assign dout = step_reg;

endmodule
